// ----- sv/vajl_pkg.sv -----
// ----------------------------------------------------------------------------
// vajl_pkg
// Shared types, constants and helpers of the velocity, acceleration and jerk
// limiter: register codes, item structs, saturation and clamp functions.
// ----------------------------------------------------------------------------
package vajl_pkg;

	localparam int Q_W   = 32;
	localparam int DT_W  = 20;
	localparam int IDX_W = 3;

	localparam int DIV_STEPS  = 32;
	localparam int LIM_STAGES = 7;
	localparam int PIPE_DEPTH = LIM_STAGES + DIV_STEPS + 2;
	localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

	localparam logic signed [Q_W-1:0] Q_MAX     = 32'sh7fff_ffff;
	localparam logic signed [Q_W-1:0] Q_MIN     = 32'sh8000_0000;
	localparam logic signed [Q_W-1:0] RATIO_ONE = 32'sh0001_0000;

	localparam int EN_VEL  = 0;
	localparam int EN_ACC  = 1;
	localparam int EN_JERK = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_LIMIT_ENABLES = 3'd0,
		REG_VEL_FLOOR     = 3'd1,
		REG_VEL_CEILING   = 3'd2,
		REG_MIN_ACCEL     = 3'd3,
		REG_MAX_ACCEL     = 3'd4,
		REG_MIN_JERK      = 3'd5,
		REG_MAX_JERK      = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]              limit_enables;
		logic signed [Q_W-1:0]   vel_floor;
		logic signed [Q_W-1:0]   vel_ceiling;
		logic signed [Q_W-1:0]   min_accel;
		logic signed [Q_W-1:0]   max_accel;
		logic signed [Q_W-1:0]   min_jerk_bound;
		logic signed [Q_W-1:0]   max_jerk_bound;
	} cfg_t;

	typedef struct packed {
		logic signed [Q_W-1:0] requested_velocity;
		logic signed [Q_W-1:0] previous_velocity;
		logic signed [Q_W-1:0] older_velocity;
		logic [DT_W-1:0]       time_step;
	} cmd_t;

	typedef struct packed {
		logic signed [Q_W-1:0] limited_velocity;
		logic signed [Q_W-1:0] requested_velocity;
	} lim_t;

	typedef struct packed {
		logic signed [Q_W-1:0] limited_velocity;
		logic signed [Q_W-1:0] limit_ratio;
	} rsp_t;

	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [41:0] x);
		logic signed [Q_W-1:0] r;
		if (x > 42'(Q_MAX)) begin
			r = Q_MAX;
		end else if (x < 42'(Q_MIN)) begin
			r = Q_MIN;
		end else begin
			r = $signed(x[Q_W-1:0]);
		end
		return r;
	endfunction

	// when the bounds cross, the lower bound wins below it and the upper bound otherwise
	function automatic logic signed [40:0] clamp_q(input logic signed [40:0] x,
		input logic signed [40:0] lo, input logic signed [40:0] hi);
		logic signed [40:0] r;
		if (x < lo) begin
			r = lo;
		end else if (x > hi) begin
			r = hi;
		end else begin
			r = x;
		end
		return r;
	endfunction

endpackage

// ----- sv/vajl_if.sv -----
// ----------------------------------------------------------------------------
// vajl_in_if / vajl_out_if
// Valid/ready channels of the limiter: command requests in, results out.
// ----------------------------------------------------------------------------
interface vajl_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [vajl_pkg::Q_W-1:0]      requested_velocity;
	logic signed [vajl_pkg::Q_W-1:0]      previous_velocity;
	logic signed [vajl_pkg::Q_W-1:0]      older_velocity;
	logic [vajl_pkg::DT_W-1:0]            time_step;

	modport source (output valid, output requested_velocity, output previous_velocity,
		output older_velocity, output time_step, input ready);
	modport sink (input valid, input requested_velocity, input previous_velocity,
		input older_velocity, input time_step, output ready);
endinterface

interface vajl_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [vajl_pkg::Q_W-1:0]      limited_velocity;
	logic signed [vajl_pkg::Q_W-1:0]      limit_ratio;

	modport source (output valid, output limited_velocity, output limit_ratio, input ready);
	modport sink (input valid, input limited_velocity, input limit_ratio, output ready);
endinterface

// ----- sv/vajl_limit.sv -----
// ----------------------------------------------------------------------------
// vajl_limit
// Seven-stage pipeline: bound products, jerk clamp, acceleration clamp and
// velocity clamp, with per-stage valid bits and a ready chain.
// ----------------------------------------------------------------------------
module vajl_limit (
	input  logic           clk,
	input  logic           arst_n,
	input  vajl_pkg::cfg_t cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  vajl_pkg::cmd_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output vajl_pkg::lim_t out_data
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;

	// stage 1
	logic signed [31:0] req_s1, v0_s1;
	logic signed [34:0] dd_s1, base_s1;
	logic [39:0]        dtsq_s1;
	logic signed [51:0] alo_p_s1, ahi_p_s1;
	// stage 2
	logic signed [31:0] req_s2, v0_s2;
	logic signed [34:0] dd_s2, base_s2;
	logic signed [35:0] alo_s2, ahi_s2;
	logic signed [56:0] jlo_p_s2, jhi_p_s2;
	// stage 3
	logic signed [31:0] req_s3, v0_s3;
	logic signed [34:0] base_s3;
	logic signed [35:0] alo_s3, ahi_s3;
	logic signed [40:0] da_s3;
	// stage 4
	logic signed [31:0] req_s4, v0_s4, vj_s4;
	logic signed [35:0] alo_s4, ahi_s4;
	// stage 5
	logic signed [31:0] req_s5, v0_s5, vj_s5;
	logic signed [35:0] dv_s5;
	// stage 6
	logic signed [31:0] req_s6, va_s6;
	// stage 7
	logic signed [31:0] req_s7, vv_s7;

	logic signed [34:0] dd_c, base_c;
	logic [39:0]        dtsq_c;
	logic signed [51:0] alo_p_c, ahi_p_c;
	logic [24:0]        dt2_c;
	logic signed [56:0] jlo_p_c, jhi_p_c;
	logic signed [40:0] jlo_c, jhi_c, da_c;
	logic signed [41:0] sum4_c, sum6_c;
	logic signed [32:0] d5_c;

	assign ld7      = !vld_s7 || out_ready;
	assign ld6      = !vld_s6 || ld7;
	assign ld5      = !vld_s5 || ld6;
	assign ld4      = !vld_s4 || ld5;
	assign ld3      = !vld_s3 || ld4;
	assign ld2      = !vld_s2 || ld3;
	assign ld1      = !vld_s1 || ld2;
	assign in_ready = ld1;

	// change of difference and the no-jerk base 2*v0 - v1
	assign dd_c   = 35'(in_data.requested_velocity) - 35'(in_data.previous_velocity)
		- 35'(in_data.previous_velocity) + 35'(in_data.older_velocity);
	assign base_c = 35'(in_data.previous_velocity) + 35'(in_data.previous_velocity)
		- 35'(in_data.older_velocity);
	assign dtsq_c  = 40'(in_data.time_step) * 40'(in_data.time_step);
	assign alo_p_c = 52'(cfg.min_accel) * 52'($signed({1'b0, in_data.time_step}));
	assign ahi_p_c = 52'(cfg.max_accel) * 52'($signed({1'b0, in_data.time_step}));

	// dt2 = (2*dt*dt) >> 16
	assign dt2_c   = dtsq_s1[39:15];
	assign jlo_p_c = 57'(cfg.min_jerk_bound) * 57'($signed({1'b0, dt2_c}));
	assign jhi_p_c = 57'(cfg.max_jerk_bound) * 57'($signed({1'b0, dt2_c}));

	assign jlo_c = $signed(jlo_p_s2[56:16]);
	assign jhi_c = $signed(jhi_p_s2[56:16]);
	assign da_c  = vajl_pkg::clamp_q(41'(dd_s2), jlo_c, jhi_c);

	assign sum4_c = 42'(base_s3) + 42'(da_s3);
	assign d5_c   = 33'(vj_s4) - 33'(v0_s4);
	assign sum6_c = 42'(v0_s5) + 42'(dv_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (ld1) vld_s1 <= in_valid;
			if (ld2) vld_s2 <= vld_s1;
			if (ld3) vld_s3 <= vld_s2;
			if (ld4) vld_s4 <= vld_s3;
			if (ld5) vld_s5 <= vld_s4;
			if (ld6) vld_s6 <= vld_s5;
			if (ld7) vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && in_valid) begin
			req_s1   <= in_data.requested_velocity;
			v0_s1    <= in_data.previous_velocity;
			dd_s1    <= dd_c;
			base_s1  <= base_c;
			dtsq_s1  <= dtsq_c;
			alo_p_s1 <= alo_p_c;
			ahi_p_s1 <= ahi_p_c;
		end
		if (ld2 && vld_s1) begin
			req_s2   <= req_s1;
			v0_s2    <= v0_s1;
			dd_s2    <= dd_s1;
			base_s2  <= base_s1;
			alo_s2   <= $signed(alo_p_s1[51:16]);
			ahi_s2   <= $signed(ahi_p_s1[51:16]);
			jlo_p_s2 <= jlo_p_c;
			jhi_p_s2 <= jhi_p_c;
		end
		if (ld3 && vld_s2) begin
			req_s3  <= req_s2;
			v0_s3   <= v0_s2;
			base_s3 <= base_s2;
			alo_s3  <= alo_s2;
			ahi_s3  <= ahi_s2;
			da_s3   <= da_c;
		end
		if (ld4 && vld_s3) begin
			req_s4 <= req_s3;
			v0_s4  <= v0_s3;
			alo_s4 <= alo_s3;
			ahi_s4 <= ahi_s3;
			vj_s4  <= cfg.limit_enables[vajl_pkg::EN_JERK] ? vajl_pkg::sat_q(sum4_c) : req_s3;
		end
		if (ld5 && vld_s4) begin
			req_s5 <= req_s4;
			v0_s5  <= v0_s4;
			vj_s5  <= vj_s4;
			dv_s5  <= 36'(vajl_pkg::clamp_q(41'(d5_c), 41'(alo_s4), 41'(ahi_s4)));
		end
		if (ld6 && vld_s5) begin
			req_s6 <= req_s5;
			va_s6  <= cfg.limit_enables[vajl_pkg::EN_ACC] ? vajl_pkg::sat_q(sum6_c) : vj_s5;
		end
		if (ld7 && vld_s6) begin
			req_s7 <= req_s6;
			vv_s7  <= cfg.limit_enables[vajl_pkg::EN_VEL]
				? 32'(vajl_pkg::clamp_q(41'(va_s6), 41'(cfg.vel_floor),
					41'(cfg.vel_ceiling)))
				: va_s6;
		end
	end

	assign out_valid                   = vld_s7;
	assign out_data.limited_velocity   = vv_s7;
	assign out_data.requested_velocity = req_s7;

endmodule

// ----- sv/vajl_div.sv -----
// ----------------------------------------------------------------------------
// vajl_div
// Pipelined restoring divider for the limit ratio: one quotient bit per
// stage, with overflow detection, sign fix-up and saturation at the end.
// ----------------------------------------------------------------------------
module vajl_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  vajl_pkg::lim_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output vajl_pkg::rsp_t out_data
);

	localparam int STEPS = vajl_pkg::DIV_STEPS;

	logic               vld_s  [0:STEPS];
	logic               ld     [0:STEPS];
	logic [31:0]        rem_s  [0:STEPS];
	logic [31:0]        num_s  [0:STEPS];
	logic [31:0]        quo_s  [0:STEPS];
	logic [31:0]        den_s  [0:STEPS];
	logic signed [31:0] lim_s  [0:STEPS];
	logic               neg_s  [0:STEPS];
	logic               ovf_s  [0:STEPS];
	logic               zero_s [0:STEPS];

	logic               vld_out_q;
	logic signed [31:0] lim_out_q, ratio_out_q;
	logic               ld_out;

	logic [31:0]        lim_u, req_u, absv_c, absd_c;
	logic               ovf_c;
	logic [31:0]        q_c;
	logic signed [31:0] ratio_c;

	assign ld_out    = !vld_out_q || out_ready;
	assign ld[STEPS] = !vld_s[STEPS] || ld_out;
	assign ld[0]     = !vld_s[0] || ld[1];
	assign in_ready  = ld[0];

	// magnitudes of numerator (limited << 16) and denominator
	assign lim_u  = in_data.limited_velocity;
	assign req_u  = in_data.requested_velocity;
	assign absv_c = lim_u[31] ? (~lim_u + 32'd1) : lim_u;
	assign absd_c = req_u[31] ? (~req_u + 32'd1) : req_u;
	// quotient of 2^32 or more saturates whatever its sign
	assign ovf_c  = {16'b0, absv_c} >= {absd_c, 16'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (ld[0]) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[0] && in_valid) begin
			rem_s[0]  <= {16'b0, absv_c[31:16]};
			num_s[0]  <= {absv_c[15:0], 16'b0};
			quo_s[0]  <= '0;
			den_s[0]  <= absd_c;
			lim_s[0]  <= in_data.limited_velocity;
			neg_s[0]  <= lim_u[31] ^ req_u[31];
			ovf_s[0]  <= ovf_c;
			zero_s[0] <= (req_u == '0);
		end
	end

	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic [32:0] trial;
		logic        ge;

		if (k < STEPS) begin : g_ld
			assign ld[k] = !vld_s[k] || ld[k+1];
		end

		assign trial = {rem_s[k-1], num_s[k-1][31]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (ld[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ld[k] && vld_s[k-1]) begin
				rem_s[k]  <= ge ? 32'(trial - {1'b0, den_s[k-1]}) : trial[31:0];
				num_s[k]  <= {num_s[k-1][30:0], 1'b0};
				quo_s[k]  <= {quo_s[k-1][30:0], ge};
				den_s[k]  <= den_s[k-1];
				lim_s[k]  <= lim_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end
		end
	end

	assign q_c = quo_s[STEPS];

	always_comb begin
		if (zero_s[STEPS]) begin
			ratio_c = vajl_pkg::RATIO_ONE;
		end else if (ovf_s[STEPS]) begin
			ratio_c = neg_s[STEPS] ? vajl_pkg::Q_MIN : vajl_pkg::Q_MAX;
		end else if (neg_s[STEPS]) begin
			ratio_c = (q_c > 32'h8000_0000) ? vajl_pkg::Q_MIN : $signed(~q_c + 32'd1);
		end else begin
			ratio_c = q_c[31] ? vajl_pkg::Q_MAX : $signed(q_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (ld_out) begin
			vld_out_q <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out && vld_s[STEPS]) begin
			lim_out_q   <= lim_s[STEPS];
			ratio_out_q <= ratio_c;
		end
	end

	assign out_valid                 = vld_out_q;
	assign out_data.limited_velocity = lim_out_q;
	assign out_data.limit_ratio      = ratio_out_q;

endmodule

// ----- sv/velocity_accel_jerk_limiter_top.sv -----
// ----------------------------------------------------------------------------
// velocity_accel_jerk_limiter_top
// Jerk, acceleration and velocity limiter for Q16.16 velocity commands.
//
// A request on cmd carries the requested velocity, the two previous commanded
// velocities and the time step; rsp returns the limited velocity and the
// ratio of limited to requested velocity (1.0 for a zero request).
// Limit bounds and enable bits are written through wr_en / wr_index / wr_data
// by the user only with no request in flight; the block does not enforce it.
// A request passes through seven limit stages, one divider setup stage,
// 32 stages of the one-bit-per-stage ratio divider and the output register.
// One request is accepted per cycle while the pipeline is not stalled.
// A stall on rsp.ready backs up only stages that hold data; empty stages keep
// filling, so cmd.ready stays high until the whole pipeline is full.
// Reset clears all valid bits and zeroes the config and in-flight count.
// ----------------------------------------------------------------------------
module velocity_accel_jerk_limiter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [vajl_pkg::IDX_W-1:0]    wr_index,
	input  logic [vajl_pkg::Q_W-1:0]      wr_data,
	vajl_in_if.sink                       cmd,
	vajl_out_if.source                    rsp
);

	vajl_pkg::cfg_t cfg_q;
	vajl_pkg::cmd_t cmd_item;
	vajl_pkg::lim_t lim_item;
	vajl_pkg::rsp_t rsp_item;
	logic           lim_valid, lim_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				vajl_pkg::REG_LIMIT_ENABLES: cfg_q.limit_enables  <= wr_data[2:0];
				vajl_pkg::REG_VEL_FLOOR:     cfg_q.vel_floor      <= $signed(wr_data);
				vajl_pkg::REG_VEL_CEILING:   cfg_q.vel_ceiling    <= $signed(wr_data);
				vajl_pkg::REG_MIN_ACCEL:     cfg_q.min_accel      <= $signed(wr_data);
				vajl_pkg::REG_MAX_ACCEL:     cfg_q.max_accel      <= $signed(wr_data);
				vajl_pkg::REG_MIN_JERK:      cfg_q.min_jerk_bound <= $signed(wr_data);
				vajl_pkg::REG_MAX_JERK:      cfg_q.max_jerk_bound <= $signed(wr_data);
				default: begin
				end
			endcase
		end
	end

	assign cmd_item.requested_velocity = cmd.requested_velocity;
	assign cmd_item.previous_velocity  = cmd.previous_velocity;
	assign cmd_item.older_velocity     = cmd.older_velocity;
	assign cmd_item.time_step          = cmd.time_step;

	vajl_limit u_limit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.in_data   (cmd_item),
		.out_valid (lim_valid),
		.out_ready (lim_ready),
		.out_data  (lim_item)
	);

	vajl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (lim_valid),
		.in_ready  (lim_ready),
		.in_data   (lim_item),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (rsp_item)
	);

	assign rsp.limited_velocity = rsp_item.limited_velocity;
	assign rsp.limit_ratio      = rsp_item.limit_ratio;

	// requests in flight
	logic [vajl_pkg::OCC_W-1:0] occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + vajl_pkg::OCC_W'(cmd.valid && cmd.ready)
				- vajl_pkg::OCC_W'(rsp.valid && rsp.ready);
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= vajl_pkg::OCC_W'(vajl_pkg::PIPE_DEPTH))
		else $error("more requests in flight than pipeline stages");

	a_empty_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> !rsp.valid)
		else $error("response without a request in flight");

	a_vel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && cfg_q.limit_enables[vajl_pkg::EN_VEL]
			&& (cfg_q.vel_floor <= cfg_q.vel_ceiling))
		|-> (rsp.limited_velocity >= cfg_q.vel_floor
			&& rsp.limited_velocity <= cfg_q.vel_ceiling))
		else $error("limited velocity outside the velocity bounds");

endmodule
